### hdl/bds_pkg.sv
// Shared types and constants for the brush dab spacing unit.
package bds_pkg;

    localparam int POS_W   = 20;
    localparam int ROT_W   = 16;
    localparam int SF_W    = 16;
    localparam int TS_W    = 11;
    localparam int LEFT_W  = 22;
    localparam int DIST_W  = 21;
    localparam int SQ_W    = 40;
    localparam int RAD_W   = 42;
    localparam int PROD_W  = 42;
    localparam int DVD_W   = 44;
    localparam int DVS_W   = 22;
    localparam int IDX_W   = 8;
    localparam int DATA_W  = 16;
    localparam int MAX_DOTS_DEF = 64;

    localparam logic [SF_W-1:0]   SF_RESET   = 16'd4096;
    localparam logic [TS_W-1:0]   TS_RESET   = 11'd10;
    localparam logic [LEFT_W-1:0] MIN_SPACE  = 22'd256;
    localparam logic [LEFT_W-1:0] LEFT_MAX   = 22'h3FFFFF;
    localparam logic [SQ_W:0]     SHORT_SQ   = 41'd7;

    localparam logic [IDX_W-1:0] REG_STEP_FACTOR = 8'd0;
    localparam logic [IDX_W-1:0] REG_TOOL_SIZE   = 8'd1;

    typedef struct packed {
        logic             clr;
        logic [POS_W-1:0] x0;
        logic [POS_W-1:0] y0;
        logic [ROT_W-1:0] r0;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } seg_t;

endpackage

### hdl/bds_fifo.sv
// Short segment queue between front and back.
module bds_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bds_pkg::seg_t wr_data,
    input  logic          pop,
    output bds_pkg::seg_t rd_data,
    output logic          not_empty,
    output logic          full
);
    bds_pkg::seg_t mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    assign rd_data   = mem[rd_ptr_reg];
    assign not_empty = (count_reg != 3'd0);
    assign full      = (count_reg == 3'd4);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 3'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 3'd1;
            end
        end
    end
endmodule

### hdl/bds_front.sv
// Front end: accepts stroke points and classifies them into segments.
module bds_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [bds_pkg::POS_W-1:0]    pos_x,
    input  logic [bds_pkg::POS_W-1:0]    pos_y,
    input  logic [bds_pkg::ROT_W-1:0]    rotation,
    input  logic                         start_stroke,
    input  logic                         q_full,
    output logic                         in_stall,
    output logic                         push,
    output bds_pkg::seg_t                seg
);
    logic [bds_pkg::POS_W-1:0] prev_x_reg;
    logic [bds_pkg::POS_W-1:0] prev_y_reg;
    logic [bds_pkg::ROT_W-1:0] prev_rot_reg;
    logic                      have_prev_reg;
    logic                      accept;
    logic                      same;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign same     = have_prev_reg && (pos_x == prev_x_reg) && (pos_y == prev_y_reg)
                      && (rotation == prev_rot_reg);
    assign push     = accept && (start_stroke || (have_prev_reg && !same));

    assign seg.clr = start_stroke;
    assign seg.x0  = prev_x_reg;
    assign seg.y0  = prev_y_reg;
    assign seg.r0  = prev_rot_reg;
    assign seg.x   = pos_x;
    assign seg.y   = pos_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_rot_reg  <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (accept && (start_stroke || !same))
        begin
            prev_x_reg    <= pos_x;
            prev_y_reg    <= pos_y;
            prev_rot_reg  <= rotation;
            have_prev_reg <= 1'b1;
        end
    end
endmodule

### hdl/bds_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module bds_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bds_pkg::DVD_W-1:0]   dividend,
    input  logic [bds_pkg::DVS_W-1:0]   divisor,
    output logic                        done,
    output logic [bds_pkg::DVD_W-1:0]   quotient,
    output logic [bds_pkg::DVS_W-1:0]   remainder
);
    localparam int CNT_W = $clog2(bds_pkg::DVD_W);

    logic [bds_pkg::DVD_W-1:0] quo_reg;
    logic [bds_pkg::DVS_W-1:0] rem_reg;
    logic [bds_pkg::DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [bds_pkg::DVS_W:0]   trial;
    logic [bds_pkg::DVS_W:0]   diff;

    assign trial     = {rem_reg, quo_reg[bds_pkg::DVD_W-1]};
    assign diff      = trial - {1'b0, dvs_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[bds_pkg::DVS_W])
            begin
                rem_reg <= diff[bds_pkg::DVS_W-1:0];
                quo_reg <= {quo_reg[bds_pkg::DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[bds_pkg::DVS_W-1:0];
                quo_reg <= {quo_reg[bds_pkg::DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(bds_pkg::DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

### hdl/bds_back.sv
// Back end: segment length, dab count and dab placement.
module bds_back
#(
    parameter int MAX_DOTS = bds_pkg::MAX_DOTS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  bds_pkg::seg_t                q_data,
    output logic                         pop,
    input  logic [bds_pkg::LEFT_W-1:0]   spacing,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bds_pkg::POS_W-1:0]    dot_x,
    output logic [bds_pkg::POS_W-1:0]    dot_y,
    output logic [bds_pkg::ROT_W-1:0]    dot_rotation,
    output logic                         last_dot,
    output logic                         overflow
);
    localparam int CW = $clog2(MAX_DOTS + 1);
    localparam int PW = bds_pkg::POS_W;
    localparam int LW = bds_pkg::LEFT_W;
    localparam int DW = bds_pkg::DIST_W;
    localparam int NW = bds_pkg::DVD_W;
    localparam int VW = bds_pkg::DVS_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    logic [2:0]  state_reg;
    bds_pkg::seg_t seg_reg;
    logic [PW-1:0] mag_x_reg, mag_y_reg;
    logic          neg_x_reg, neg_y_reg;
    logic [bds_pkg::SQ_W-1:0]  sqx_reg, sqy_reg;
    logic [bds_pkg::RAD_W-1:0] rad_reg;
    logic [LW-1:0] rem_reg;
    logic [DW-1:0] root_reg;
    logic [4:0]    it_reg;
    logic [LW-1:0] left_reg;
    logic [LW-1:0] span_reg;
    logic [bds_pkg::PROD_W-1:0] pxl_reg, pxs_reg, pyl_reg, pys_reg;
    logic [LW-1:0] offx_reg, offy_reg, stqx_reg, stqy_reg;
    logic [VW:0]   remx_reg, remy_reg, strx_reg, stry_reg;
    logic [CW-1:0] k_reg, emit_reg;
    logic          ovf_reg;
    logic          out_valid_reg;
    logic [PW-1:0] dot_x_reg, dot_y_reg;
    logic [bds_pkg::ROT_W-1:0] dot_rot_reg;
    logic          last_reg, ovfo_reg;

    logic [bds_pkg::SQ_W:0] d2;
    logic [LW+1:0] rem_t, trial;
    logic [VW-1:0] two_dist;
    logic          div_start;
    logic [NW-1:0] dvd_xi, dvd_xs, dvd_yi, dvd_ys, dvd_sp;
    logic [NW-1:0] q_xi, q_xs, q_yi, q_ys, q_sp;
    logic [VW-1:0] r_xi, r_xs, r_yi, r_ys, r_sp;
    logic          dn_xi, dn_xs, dn_yi, dn_ys, dn_sp;
    logic          load;
    logic          is_last;
    logic [VW:0]   sumx, sumy;
    logic          cx, cy;

    assign d2       = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign rem_t    = {rem_reg, rad_reg[bds_pkg::RAD_W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign two_dist = {root_reg, 1'b0};
    assign div_start = (state_reg == ST_MUL);
    assign dvd_sp   = NW'(span_reg);
    assign dvd_xi   = {1'b0, pxl_reg, 1'b0} + NW'(root_reg);
    assign dvd_yi   = {1'b0, pyl_reg, 1'b0} + NW'(root_reg);
    assign dvd_xs   = {1'b0, pxs_reg, 1'b0};
    assign dvd_ys   = {1'b0, pys_reg, 1'b0};
    assign pop      = (state_reg == ST_IDLE) && q_valid;
    assign load     = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign is_last  = ((k_reg + 1'b1) == emit_reg);
    assign sumx     = remx_reg + strx_reg;
    assign sumy     = remy_reg + stry_reg;
    assign cx       = (sumx >= {1'b0, two_dist});
    assign cy       = (sumy >= {1'b0, two_dist});

    bds_div u_div_sp (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_sp),
                      .divisor(spacing), .done(dn_sp), .quotient(q_sp), .remainder(r_sp));
    bds_div u_div_xi (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_xi),
                      .divisor(two_dist), .done(dn_xi), .quotient(q_xi), .remainder(r_xi));
    bds_div u_div_xs (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_xs),
                      .divisor(two_dist), .done(dn_xs), .quotient(q_xs), .remainder(r_xs));
    bds_div u_div_yi (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_yi),
                      .divisor(two_dist), .done(dn_yi), .quotient(q_yi), .remainder(r_yi));
    bds_div u_div_ys (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_ys),
                      .divisor(two_dist), .done(dn_ys), .quotient(q_ys), .remainder(r_ys));

    assign out_valid    = out_valid_reg;
    assign dot_x        = dot_x_reg;
    assign dot_y        = dot_y_reg;
    assign dot_rotation = dot_rot_reg;
    assign last_dot     = last_reg;
    assign overflow     = ovfo_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                seg_reg   <= q_data;
                neg_x_reg <= (q_data.x < q_data.x0);
                neg_y_reg <= (q_data.y < q_data.y0);
                mag_x_reg <= (q_data.x >= q_data.x0) ? q_data.x - q_data.x0
                                                     : q_data.x0 - q_data.x;
                mag_y_reg <= (q_data.y >= q_data.y0) ? q_data.y - q_data.y0
                                                     : q_data.y0 - q_data.y;
            end
            ST_SQ:
            begin
                sqx_reg <= mag_x_reg * mag_x_reg;
                sqy_reg <= mag_y_reg * mag_y_reg;
            end
            ST_SUM:
            begin
                rad_reg  <= {1'b0, d2};
                rem_reg  <= '0;
                root_reg <= '0;
                it_reg   <= '0;
            end
            ST_SQRT:
            begin
                rad_reg <= {rad_reg[bds_pkg::RAD_W-3:0], 2'b00};
                it_reg  <= it_reg + 5'd1;
                if (rem_t >= trial)
                begin
                    rem_reg  <= LW'(rem_t - trial);
                    root_reg <= {root_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= LW'(rem_t);
                    root_reg <= {root_reg[DW-2:0], 1'b0};
                end
            end
            ST_CHK:
            begin
                span_reg <= LW'(root_reg) - left_reg;
                pxl_reg  <= mag_x_reg * left_reg;
                pxs_reg  <= mag_x_reg * spacing;
                pyl_reg  <= mag_y_reg * left_reg;
                pys_reg  <= mag_y_reg * spacing;
            end
            ST_DIV:
            begin
                offx_reg <= LW'(q_xi);
                offy_reg <= LW'(q_yi);
                remx_reg <= {1'b0, r_xi};
                remy_reg <= {1'b0, r_yi};
                stqx_reg <= LW'(q_xs);
                stqy_reg <= LW'(q_ys);
                strx_reg <= {1'b0, r_xs};
                stry_reg <= {1'b0, r_ys};
                ovf_reg  <= (q_sp >= NW'(MAX_DOTS));
                emit_reg <= (q_sp >= NW'(MAX_DOTS)) ? CW'(MAX_DOTS) : CW'(q_sp + 1'b1);
                k_reg    <= '0;
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    k_reg    <= k_reg + 1'b1;
                    offx_reg <= offx_reg + stqx_reg + LW'(cx);
                    offy_reg <= offy_reg + stqy_reg + LW'(cy);
                    remx_reg <= cx ? sumx - {1'b0, two_dist} : sumx;
                    remy_reg <= cy ? sumy - {1'b0, two_dist} : sumy;
                end
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            dot_x_reg   <= neg_x_reg ? seg_reg.x0 - PW'(offx_reg) : seg_reg.x0 + PW'(offx_reg);
            dot_y_reg   <= neg_y_reg ? seg_reg.y0 - PW'(offy_reg) : seg_reg.y0 + PW'(offy_reg);
            dot_rot_reg <= seg_reg.r0;
            last_reg    <= is_last;
            ovfo_reg    <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= load ? 1'b1 : (out_valid_reg && out_stall);
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_data.clr)
                        begin
                            left_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= (d2 < bds_pkg::SHORT_SQ) ? ST_IDLE : ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (it_reg == 5'(DW - 1))
                    begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    if (left_reg > LW'(root_reg))
                    begin
                        left_reg  <= left_reg - LW'(root_reg);
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (dn_sp && dn_xi && dn_xs && dn_yi && dn_ys)
                    begin
                        left_reg  <= spacing - r_sp;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (load && is_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

### hdl/brush_dab_spacing_unit.sv
// Brush dab spacing unit: top level with configuration registers.
// Path: a segment is dequeued, squared, square-rooted, set up and divided, and each dab
// then passes an output register before it is valid.
// The bit-serial root and dividers work on one segment at a time; short segments,
// segments inside the leftover and stroke starts take shorter paths.
// Reset (rst_n, asynchronous, low): clears queue, previous point and leftover,
// and loads step_factor 1.0 and tool_size 10.
module brush_dab_spacing_unit
#(
    parameter int MAX_DOTS = bds_pkg::MAX_DOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bds_pkg::POS_W-1:0]     pos_x,
    input  logic [bds_pkg::POS_W-1:0]     pos_y,
    input  logic [bds_pkg::ROT_W-1:0]     rotation,
    input  logic                          start_stroke,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bds_pkg::POS_W-1:0]     dot_x,
    output logic [bds_pkg::POS_W-1:0]     dot_y,
    output logic [bds_pkg::ROT_W-1:0]     dot_rotation,
    output logic                          last_dot,
    output logic                          overflow,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bds_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bds_pkg::DATA_W-1:0]    cfg_data
);
    logic [bds_pkg::SF_W-1:0]   step_factor_reg;
    logic [bds_pkg::TS_W-1:0]   tool_size_reg;
    logic [bds_pkg::LEFT_W-1:0] spacing_reg;
    logic [bds_pkg::SF_W+bds_pkg::TS_W-1:0] sprod;
    logic [bds_pkg::SF_W+bds_pkg::TS_W-5:0] sraw;
    logic [bds_pkg::LEFT_W-1:0] spacing_next;

    logic          push, pop, q_valid, q_full;
    bds_pkg::seg_t seg_in, seg_out;

    assign cfg_ready = 1'b1;
    assign sprod = step_factor_reg * tool_size_reg;
    assign sraw  = sprod[bds_pkg::SF_W+bds_pkg::TS_W-1:4];

    always_comb
    begin
        if (sraw > {1'b0, bds_pkg::LEFT_MAX})
        begin
            spacing_next = bds_pkg::LEFT_MAX;
        end
        else if (sraw < {1'b0, bds_pkg::MIN_SPACE})
        begin
            spacing_next = bds_pkg::MIN_SPACE;
        end
        else
        begin
            spacing_next = sraw[bds_pkg::LEFT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_factor_reg <= bds_pkg::SF_RESET;
            tool_size_reg   <= bds_pkg::TS_RESET;
            spacing_reg     <= bds_pkg::MIN_SPACE;
        end
        else
        begin
            spacing_reg <= spacing_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bds_pkg::REG_STEP_FACTOR: step_factor_reg <= cfg_data;
                    bds_pkg::REG_TOOL_SIZE:   tool_size_reg <= cfg_data[bds_pkg::TS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    bds_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .pos_x(pos_x), .pos_y(pos_y),
        .rotation(rotation), .start_stroke(start_stroke), .q_full(q_full),
        .in_stall(in_stall), .push(push), .seg(seg_in)
    );

    bds_fifo u_fifo
    (
        .clk(clk), .rst_n(rst_n), .push(push), .wr_data(seg_in), .pop(pop),
        .rd_data(seg_out), .not_empty(q_valid), .full(q_full)
    );

    bds_back #(.MAX_DOTS(MAX_DOTS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(seg_out), .pop(pop),
        .spacing(spacing_reg), .out_valid(out_valid), .out_stall(out_stall),
        .dot_x(dot_x), .dot_y(dot_y), .dot_rotation(dot_rotation),
        .last_dot(last_dot), .overflow(overflow)
    );
endmodule

### tb/testbench.sv
// Self-checking testbench for the brush dab spacing unit with its own dab placement predictor.
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [bds_pkg::POS_W-1:0] x;
        logic [bds_pkg::POS_W-1:0] y;
        logic [bds_pkg::ROT_W-1:0] r;
        logic                      last;
        logic                      ovf;
    } dab_t;

    typedef struct {
        logic [bds_pkg::POS_W-1:0] x;
        logic [bds_pkg::POS_W-1:0] y;
        logic [bds_pkg::ROT_W-1:0] r;
        logic                      st;
        int                        dabs;
    } point_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [bds_pkg::POS_W-1:0]   pos_x;
    logic [bds_pkg::POS_W-1:0]   pos_y;
    logic [bds_pkg::ROT_W-1:0]   rotation;
    logic                        start_stroke;
    logic                        out_valid;
    logic                        out_stall;
    logic [bds_pkg::POS_W-1:0]   dot_x;
    logic [bds_pkg::POS_W-1:0]   dot_y;
    logic [bds_pkg::ROT_W-1:0]   dot_rotation;
    logic                        last_dot;
    logic                        overflow;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [bds_pkg::IDX_W-1:0]   cfg_index;
    logic [bds_pkg::DATA_W-1:0]  cfg_data;

    dab_t                        expected_dabs[$];
    int                          errors;
    int                          send_idle_pct;
    int                          recv_stall_pct;
    int                          dab_count;

    logic [bds_pkg::SF_W-1:0]    m_step;
    logic [bds_pkg::TS_W-1:0]    m_size;
    logic [bds_pkg::POS_W-1:0]   m_px;
    logic [bds_pkg::POS_W-1:0]   m_py;
    logic [bds_pkg::ROT_W-1:0]   m_pr;
    logic                        m_have;
    logic [bds_pkg::LEFT_W-1:0]  m_owed;

    logic [bds_pkg::POS_W-1:0]   cur_x;
    logic [bds_pkg::POS_W-1:0]   cur_y;
    logic [bds_pkg::ROT_W-1:0]   cur_r;

    brush_dab_spacing_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .rotation     (rotation),
        .start_stroke (start_stroke),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dot_x        (dot_x),
        .dot_y        (dot_y),
        .dot_rotation (dot_rotation),
        .last_dot     (last_dot),
        .overflow     (overflow),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned trial;
        res = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = res | (64'd1 << b);
            if (trial * trial <= v)
                res = trial;
        end
        return res;
    endfunction

    function automatic logic [bds_pkg::POS_W-1:0] dab_coord(
        input logic [bds_pkg::POS_W-1:0] p0,
        input logic [bds_pkg::POS_W-1:0] p1,
        input longint unsigned t,
        input longint unsigned seg_len);
        longint unsigned mag;
        longint unsigned off;
        mag = (p1 >= p0) ? longint'(p1 - p0) : longint'(p0 - p1);
        off = (mag * t * 2 + seg_len) / (seg_len * 2);
        if (p1 >= p0)
            return bds_pkg::POS_W'(longint'(p0) + off);
        return bds_pkg::POS_W'(longint'(p0) - off);
    endfunction

    task automatic predict_dabs(input logic [bds_pkg::POS_W-1:0] x,
                                input logic [bds_pkg::POS_W-1:0] y,
                                input logic [bds_pkg::ROT_W-1:0] r, input logic st);
        logic [bds_pkg::POS_W-1:0] x0;
        logic [bds_pkg::POS_W-1:0] y0;
        logic [bds_pkg::ROT_W-1:0] r0;
        longint unsigned adx;
        longint unsigned ady;
        longint unsigned d2;
        longint unsigned seg_len;
        longint unsigned sp;
        longint unsigned total;
        longint unsigned emit;
        longint unsigned t;
        dab_t d;
        x0 = m_px;
        y0 = m_py;
        r0 = m_pr;
        dab_count = 0;
        if (st)
        begin
            m_have = 1'b0;
            m_owed = '0;
        end
        else if (m_have && x == x0 && y == y0 && r == r0)
            return;
        m_px = x;
        m_py = y;
        m_pr = r;
        if (!m_have)
        begin
            m_have = 1'b1;
            return;
        end
        adx = (x >= x0) ? longint'(x - x0) : longint'(x0 - x);
        ady = (y >= y0) ? longint'(y - y0) : longint'(y0 - y);
        d2 = adx * adx + ady * ady;
        if (d2 < bds_pkg::SHORT_SQ)
            return;
        seg_len = root_floor(d2);
        if (longint'(m_owed) > seg_len)
        begin
            m_owed = bds_pkg::LEFT_W'(longint'(m_owed) - seg_len);
            return;
        end
        sp = (longint'(m_step) * longint'(m_size)) >> 4;
        if (sp < bds_pkg::MIN_SPACE)
            sp = bds_pkg::MIN_SPACE;
        if (sp > bds_pkg::LEFT_MAX)
            sp = bds_pkg::LEFT_MAX;
        total = (seg_len - longint'(m_owed)) / sp + 1;
        emit = (total > bds_pkg::MAX_DOTS_DEF) ? bds_pkg::MAX_DOTS_DEF : total;
        for (longint unsigned k = 0; k < emit; k++)
        begin
            t = longint'(m_owed) + k * sp;
            d.x = dab_coord(x0, x, t, seg_len);
            d.y = dab_coord(y0, y, t, seg_len);
            d.r = r0;
            d.last = (k + 1 == emit);
            d.ovf = (total > bds_pkg::MAX_DOTS_DEF);
            expected_dabs.insert(expected_dabs.size(), d);
            dab_count++;
        end
        m_owed = bds_pkg::LEFT_W'(longint'(m_owed) + total * sp - seg_len);
    endtask

    task automatic send_point(input logic [bds_pkg::POS_W-1:0] x,
                              input logic [bds_pkg::POS_W-1:0] y,
                              input logic [bds_pkg::ROT_W-1:0] r, input logic st);
        logic done;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                continue;
            end
            in_valid <= 1'b1;
            pos_x <= x;
            pos_y <= y;
            rotation <= r;
            start_stroke <= st;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            done = 1'b1;
            predict_dabs(x, y, r, st);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_dabs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [bds_pkg::IDX_W-1:0] idx,
                             input logic [bds_pkg::DATA_W-1:0] val);
        drain();
        repeat (200) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == bds_pkg::REG_STEP_FACTOR)
            m_step = val;
        else if (idx == bds_pkg::REG_TOOL_SIZE)
            m_size = bds_pkg::TS_W'(val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk)
    begin
        dab_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_dabs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected dab x=%h y=%h", $time, dot_x, dot_y);
            end
            else
            begin
                e = expected_dabs.pop_front();
                if (dot_x !== e.x || dot_y !== e.y || dot_rotation !== e.r
                    || last_dot !== e.last || overflow !== e.ovf)
                begin
                    errors++;
                    $display("%0t: dab mismatch exp x=%h y=%h r=%h l=%b o=%b",
                             $time, e.x, e.y, e.r, e.last, e.ovf);
                    $display("%0t:              got x=%h y=%h r=%h l=%b o=%b",
                             $time, dot_x, dot_y, dot_rotation, last_dot, overflow);
                end
            end
        end
    end

    task automatic random_point();
        int pick;
        int dx;
        int dy;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            cur_x = bds_pkg::POS_W'($urandom);
            cur_y = bds_pkg::POS_W'($urandom);
            cur_r = bds_pkg::ROT_W'($urandom);
            send_point(cur_x, cur_y, cur_r, 1'b1);
            return;
        end
        if (pick < 10)
        begin
            send_point(cur_x, cur_y, cur_r, 1'b0);
            return;
        end
        if (pick < 14)
        begin
            cur_x = bds_pkg::POS_W'($urandom);
            cur_y = bds_pkg::POS_W'($urandom);
            cur_r = bds_pkg::ROT_W'($urandom);
        end
        else if (pick < 20)
        begin
            cur_x = bds_pkg::POS_W'(cur_x + $urandom_range(0, 2) - 1);
            cur_y = bds_pkg::POS_W'(cur_y + $urandom_range(0, 2) - 1);
        end
        else
        begin
            dx = int'($urandom_range(0, 6000)) - 3000;
            dy = int'($urandom_range(0, 6000)) - 3000;
            cur_x = cur_x + bds_pkg::POS_W'(dx);
            cur_y = cur_y + bds_pkg::POS_W'(dy);
            if ($urandom_range(0, 3) == 0)
                cur_r = cur_r + bds_pkg::ROT_W'($urandom_range(0, 512));
        end
        send_point(cur_x, cur_y, cur_r, 1'b0);
    endtask

    point_row_t directed[] = '{
        '{20'd0,       20'd0,       16'h0000, 1'b1, 0},
        '{20'd5120,    20'd0,       16'h1234, 1'b0, 3},
        '{20'd5120,    20'd0,       16'h1234, 1'b0, 0},
        '{20'd5121,    20'd1,       16'h1234, 1'b0, 0},
        '{20'd5121,    20'd300,     16'h1234, 1'b0, 0},
        '{20'd5121,    20'd9000,    16'hFFFF, 1'b0, -1},
        '{20'hFFFFF,   20'hFFFFF,   16'hFFFF, 1'b1, 0},
        '{20'd0,       20'd0,       16'h0000, 1'b0, 64},
        '{20'd0,       20'd0,       16'h0000, 1'b0, 0},
        '{20'd2000,    20'd0,       16'h8000, 1'b0, -1},
        '{20'd2000,    20'd0,       16'h8001, 1'b0, -1},
        '{20'd0,       20'd1500,    16'h7FFF, 1'b0, -1},
        '{20'hFFFFF,   20'd0,       16'hAAAA, 1'b0, 64},
        '{20'hFFFF0,   20'd2,       16'h5555, 1'b0, -1},
        '{20'h12345,   20'hABCDE,   16'h0F0F, 1'b1, 0},
        '{20'h12345,   20'hABCDE,   16'h0F0F, 1'b1, 0},
        '{20'h12300,   20'hABD00,   16'h0F0F, 1'b0, -1}
    };

    initial
    begin
        logic [bds_pkg::SF_W-1:0] steps[6] = '{16'd0, 16'd65535, 16'd65535, 16'd4096,
                                                16'd1234, 16'd0};
        logic [bds_pkg::DATA_W-1:0] sizes[6] = '{16'd1, 16'd1024, 16'd2047, 16'd0,
                                                  16'd37, 16'd1024};
        int sent;
        int idle_mode;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        rotation = '0;
        start_stroke = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = bds_pkg::REG_STEP_FACTOR;
        cfg_data = '0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        m_step = bds_pkg::SF_RESET;
        m_size = bds_pkg::TS_RESET;
        m_px = '0;
        m_py = '0;
        m_pr = '0;
        m_have = 1'b0;
        m_owed = '0;
        cur_x = '0;
        cur_y = '0;
        cur_r = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            send_point(directed[i].x, directed[i].y, directed[i].r, directed[i].st);
            if (directed[i].dabs >= 0 && dab_count != directed[i].dabs)
            begin
                errors++;
                $display("%0t: dab count exp %0d got %0d", $time, directed[i].dabs, dab_count);
            end
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(bds_pkg::REG_STEP_FACTOR, steps[ph]);
            write_reg(bds_pkg::REG_TOOL_SIZE, sizes[ph]);
            cur_x = bds_pkg::POS_W'($urandom);
            cur_y = bds_pkg::POS_W'($urandom);
            send_point(cur_x, cur_y, cur_r, 1'b1);
            sent = 0;
            while (sent < 68)
            begin
                idle_mode = (sent / 17 + ph) % 4;
                send_idle_pct = (idle_mode == 1) ? 53 : (idle_mode == 3) ? 14 : 0;
                recv_stall_pct = (idle_mode == 2) ? 53 : (idle_mode == 3) ? 14 : 0;
                random_point();
                sent++;
                if (sent == 34)
                    drain();
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
